// ----- rtl/pwm_duty_temperature_decoder_macros.svh -----
// Assertion macros for the PWM duty temperature decoder.
// Included by the modules that carry concurrent assertions; expects aclk and aresetn in scope.
`ifndef PWM_DUTY_TEMPERATURE_DECODER_MACROS_SVH
`define PWM_DUTY_TEMPERATURE_DECODER_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked only outside reset
`define PDTD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("pdtd assertion failed");

// checked on every edge, reset included
`define PDTD_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("pdtd assertion failed");

`else

`define PDTD_ASSERT(lbl, prop)
`define PDTD_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// ----- rtl/pdtd_pkg.sv -----
// Shared types and constants of the PWM duty temperature decoder.
// No dependencies; used by pdtd_div and pwm_duty_temperature_decoder.
package pdtd_pkg;

    localparam int CW        = 16;  // capture counter and length width
    localparam int AVG_CNT_W = 7;   // average_count register width
    localparam int IDX_W     = 2;   // config register index width
    localparam int DUTY_W    = 10;  // duty per mille, always below 1000
    localparam int PROD_W    = 26;  // 16 bit pulse times 1000
    localparam int TPROD_W   = 41;  // duty times TEMP_RECIP
    localparam int TEMP_W    = 15;

    localparam logic [IDX_W-1:0] REG_MIN_LEN   = 2'd0;
    localparam logic [IDX_W-1:0] REG_MAX_LEN   = 2'd1;
    localparam logic [IDX_W-1:0] REG_AVG_COUNT = 2'd2;

    localparam logic [CW-1:0]        MIN_LEN_RST   = 16'd250;
    localparam logic [CW-1:0]        MAX_LEN_RST   = 16'd40000;
    localparam logic [AVG_CNT_W-1:0] AVG_COUNT_RST = 7'd24;

    localparam logic CMD_EDGE = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [9:0]    SCALE_DUTY   = 10'd1000;
    localparam logic [13:0]   SCALE_TEMP   = 14'd10000;
    localparam logic [CW-1:0] DUTY_DIVISOR = 16'd470;
    localparam logic [CW-1:0] TEMP_OFFSET  = 16'd6809;

    // duty * 10000 / 470 == duty * 1000 / 47; 1000 * ceil(2^26 / 47), exact for duty < 1000
    localparam int          TEMP_SHIFT = 26;
    localparam logic [30:0] TEMP_RECIP = 31'd1427849000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_PER,
        ST_DIV_HIGH,
        ST_DIV_DUTY,
        ST_DIV_TEMP,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ----- rtl/pdtd_div.sv -----
// Restoring radix-2 divider shared by the averaging and duty steps.
// One quotient bit per cycle; depends on pdtd_pkg.
module pdtd_div #(
    parameter int DW = 26
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  pdtd_pkg::div_ctrl_t    ctrl,
    input  logic [DW-1:0]          dividend,
    input  logic [pdtd_pkg::CW-1:0] divisor,
    output pdtd_pkg::div_stat_t    stat,
    output logic [DW-1:0]          quotient
);
    localparam int CW    = pdtd_pkg::CW;
    localparam int CNT_W = $clog2(DW + 1);

    logic [DW-1:0]    quo_reg, quo_next;
    logic [CW-1:0]    rem_reg, rem_next;
    logic [CW-1:0]    dsr_reg, dsr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [CW:0] trial;
    logic [CW:0] diff;
    logic        ge;

    always_comb begin
        trial = {rem_reg, quo_reg[DW-1]};
        diff  = trial - {1'b0, dsr_reg};
        ge    = (trial >= {1'b0, dsr_reg});

        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (busy_reg) begin
            rem_next = ge ? diff[CW-1:0] : trial[CW-1:0];
            quo_next = {quo_reg[DW-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (ctrl.start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = CNT_W'(DW);
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

// ----- rtl/pwm_duty_temperature_decoder.sv -----
// PWM duty temperature decoder: averages pulse/period pairs, converts duty to centidegrees.
// Edge event without a completed average: handled in idle. Edge completing an average: period and
// pulse divisions on the shared divider, DW = max(16 + clog2(MAX_AVERAGE), 26), i.e. 26 at defaults.
// Valid read: duty division, reciprocal multiply, then the result is registered for the output;
// invalid read: no division; a stalled result holds ST_OUT. Synchronous active-low reset
// clears measurement state, loads register defaults. Uses pdtd_pkg, pdtd_div, the macros header.
`include "pwm_duty_temperature_decoder_macros.svh"

module pwm_duty_temperature_decoder #(
    parameter int MAX_AVERAGE = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // edge / read channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_command,
    input  logic                              s_edge_rising,
    input  logic [pdtd_pkg::CW-1:0]           s_capture_time,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [pdtd_pkg::TEMP_W-1:0] m_temperature_centi,
    output logic                              m_temp_valid,
    output logic [pdtd_pkg::CW-1:0]           m_average_pulse,
    output logic [pdtd_pkg::CW-1:0]           m_average_period,
    // config writes
    input  logic                              cfg_wr_en,
    input  logic [pdtd_pkg::IDX_W-1:0]        cfg_index,
    input  logic [pdtd_pkg::CW-1:0]           cfg_wdata
);
    localparam int CW     = pdtd_pkg::CW;
    localparam int ACW    = pdtd_pkg::AVG_CNT_W;
    localparam int TW     = pdtd_pkg::TEMP_W;
    localparam int PW     = pdtd_pkg::PROD_W;
    localparam int TPW    = pdtd_pkg::TPROD_W;
    localparam int CNT_W  = $clog2(MAX_AVERAGE + 1);
    localparam int SUM_W  = CW + $clog2(MAX_AVERAGE);
    localparam int CMP_W  = (CNT_W > ACW) ? CNT_W : ACW;
    localparam int DW     = (SUM_W > pdtd_pkg::PROD_W) ? SUM_W : pdtd_pkg::PROD_W;

    // config registers
    logic [CW-1:0]  min_len_reg;
    logic [CW-1:0]  max_len_reg;
    logic [ACW-1:0] avg_count_reg;

    // measurement state
    pdtd_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    period_start_reg, period_start_next;
    logic             start_seen_reg, start_seen_next;
    logic [CW-1:0]    last_high_reg, last_high_next;
    logic [SUM_W-1:0] high_sum_reg, high_sum_next;
    logic [SUM_W-1:0] period_sum_reg, period_sum_next;
    logic [CNT_W-1:0] pair_count_reg, pair_count_next;
    logic [CW-1:0]    avg_high_reg, avg_high_next;
    logic [CW-1:0]    avg_period_reg, avg_period_next;

    // read result
    logic signed [TW-1:0] temp_reg, temp_next;
    logic                 tvalid_reg, tvalid_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 out_load;
    logic signed [TW-1:0] m_temp_reg;
    logic                 m_tvalid_reg;
    logic [CW-1:0]        m_pulse_reg;
    logic [CW-1:0]        m_period_reg;

    // shared divider
    pdtd_pkg::div_ctrl_t div_ctrl;
    pdtd_pkg::div_stat_t div_stat;
    logic [DW-1:0]       div_dividend;
    logic [CW-1:0]       div_divisor;
    logic [DW-1:0]       div_quotient;

    // datapath helpers
    logic [CW-1:0]    delta;
    logic             per_ok, high_ok;
    logic [CMP_W-1:0] cnt_inc, target, ac_ext, max_ext;
    logic [SUM_W-1:0] period_sum_add, high_sum_add;
    logic [pdtd_pkg::PROD_W-1:0]  duty_prod;
    logic [pdtd_pkg::TPROD_W-1:0] temp_prod;
    logic [CW-1:0]                temp_calc;

    pdtd_div #(
        .DW (DW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (div_ctrl),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

    always_comb begin
        delta   = s_capture_time - period_start_reg;
        per_ok  = (delta > min_len_reg) && (delta < max_len_reg);
        high_ok = (last_high_reg > min_len_reg) && (last_high_reg < max_len_reg);
        cnt_inc = CMP_W'(pair_count_reg) + CMP_W'(1);
        ac_ext  = CMP_W'(avg_count_reg);
        max_ext = CMP_W'(MAX_AVERAGE);
        if (ac_ext == '0) begin
            target = CMP_W'(1);
        end else if (ac_ext > max_ext) begin
            target = max_ext;
        end else begin
            target = ac_ext;
        end
        period_sum_add = period_sum_reg + SUM_W'(delta);
        high_sum_add   = high_sum_reg + SUM_W'(last_high_reg);
        duty_prod      = PW'(avg_high_reg) * PW'(pdtd_pkg::SCALE_DUTY);
        temp_prod      = TPW'(div_quotient[pdtd_pkg::DUTY_W-1:0]) * TPW'(pdtd_pkg::TEMP_RECIP);
        temp_calc      = CW'(temp_prod[TPW-1:pdtd_pkg::TEMP_SHIFT]) - pdtd_pkg::TEMP_OFFSET;
    end

    always_comb begin
        state_next        = state_reg;
        period_start_next = period_start_reg;
        start_seen_next   = start_seen_reg;
        last_high_next    = last_high_reg;
        high_sum_next     = high_sum_reg;
        period_sum_next   = period_sum_reg;
        pair_count_next   = pair_count_reg;
        avg_high_next     = avg_high_reg;
        avg_period_next   = avg_period_reg;
        temp_next         = temp_reg;
        tvalid_next       = tvalid_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        out_load          = 1'b0;
        s_ready           = 1'b0;
        div_ctrl.start    = 1'b0;
        div_dividend      = DW'(period_sum_add);
        div_divisor       = CW'(cnt_inc);

        unique case (state_reg)
            pdtd_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_command == pdtd_pkg::CMD_READ) begin
                        start_seen_next = 1'b0;
                        last_high_next  = '0;
                        if (avg_high_reg < avg_period_reg) begin
                            div_ctrl.start = 1'b1;
                            div_dividend   = DW'(duty_prod);
                            div_divisor    = avg_period_reg;
                            state_next     = pdtd_pkg::ST_DIV_DUTY;
                        end else begin
                            temp_next   = '0;
                            tvalid_next = 1'b0;
                            state_next  = pdtd_pkg::ST_OUT;
                        end
                    end else if (s_edge_rising) begin
                        period_start_next = s_capture_time;
                        start_seen_next   = 1'b1;
                        if (start_seen_reg && per_ok && high_ok) begin
                            period_sum_next = period_sum_add;
                            high_sum_next   = high_sum_add;
                            pair_count_next = cnt_inc[CNT_W-1:0];
                            if (cnt_inc >= target) begin
                                // average the period now, pulse after it
                                div_ctrl.start = 1'b1;
                                state_next     = pdtd_pkg::ST_DIV_PER;
                            end
                        end
                    end else if (start_seen_reg) begin
                        last_high_next = delta;
                    end
                end
            end
            pdtd_pkg::ST_DIV_PER: begin
                div_dividend = DW'(high_sum_reg);
                div_divisor  = CW'(pair_count_reg);
                if (div_stat.done) begin
                    avg_period_next = div_quotient[CW-1:0];
                    div_ctrl.start  = 1'b1;
                    high_sum_next   = '0;
                    period_sum_next = '0;
                    pair_count_next = '0;
                    state_next      = pdtd_pkg::ST_DIV_HIGH;
                end
            end
            pdtd_pkg::ST_DIV_HIGH: begin
                if (div_stat.done) begin
                    avg_high_next = div_quotient[CW-1:0];
                    state_next    = pdtd_pkg::ST_IDLE;
                end
            end
            pdtd_pkg::ST_DIV_DUTY: begin
                if (div_stat.done) begin
                    state_next = pdtd_pkg::ST_DIV_TEMP;
                end
            end
            pdtd_pkg::ST_DIV_TEMP: begin
                // duty stays in the idle divider; scale it by reciprocal multiply
                temp_next   = $signed(temp_calc[TW-1:0]);
                tvalid_next = 1'b1;
                state_next  = pdtd_pkg::ST_OUT;
            end
            pdtd_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = pdtd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pdtd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_len_reg   <= pdtd_pkg::MIN_LEN_RST;
            max_len_reg   <= pdtd_pkg::MAX_LEN_RST;
            avg_count_reg <= pdtd_pkg::AVG_COUNT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                pdtd_pkg::REG_MIN_LEN:   min_len_reg   <= cfg_wdata;
                pdtd_pkg::REG_MAX_LEN:   max_len_reg   <= cfg_wdata;
                pdtd_pkg::REG_AVG_COUNT: avg_count_reg <= cfg_wdata[ACW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= pdtd_pkg::ST_IDLE;
            period_start_reg <= '0;
            start_seen_reg   <= 1'b0;
            last_high_reg    <= '0;
            high_sum_reg     <= '0;
            period_sum_reg   <= '0;
            pair_count_reg   <= '0;
            avg_high_reg     <= '0;
            avg_period_reg   <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            period_start_reg <= period_start_next;
            start_seen_reg   <= start_seen_next;
            last_high_reg    <= last_high_next;
            high_sum_reg     <= high_sum_next;
            period_sum_reg   <= period_sum_next;
            pair_count_reg   <= pair_count_next;
            avg_high_reg     <= avg_high_next;
            avg_period_reg   <= avg_period_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        temp_reg   <= temp_next;
        tvalid_reg <= tvalid_next;
        if (out_load) begin
            m_temp_reg   <= temp_reg;
            m_tvalid_reg <= tvalid_reg;
            m_pulse_reg  <= avg_high_reg;
            m_period_reg <= avg_period_reg;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_temperature_centi = m_temp_reg;
    assign m_temp_valid        = m_tvalid_reg;
    assign m_average_pulse     = m_pulse_reg;
    assign m_average_period    = m_period_reg;

    `PDTD_ASSERT(a_ready_div_idle, s_ready |-> !div_stat.busy)
    `PDTD_ASSERT(a_pair_count_bound, pair_count_reg <= CNT_W'(MAX_AVERAGE))
    `PDTD_ASSERT(a_read_rearms, (s_valid && s_ready && s_command) |=> !start_seen_reg)
    `PDTD_ASSERT(a_invalid_zero, (m_valid && !m_temp_valid) |-> (m_temperature_centi == '0))
    `PDTD_ASSERT_ALWAYS(a_reset_no_out, !aresetn |=> !m_valid)

endmodule
